>>> hw/rtl/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// Holds the item structs, the register map and the ranging constants.
// No dependencies.
package uer_pkg;

    // Counter width of the wait and echo-width counters; capped at 16 bits.
    localparam int COUNT_WIDTH = 16;
    localparam int CNT_W       = (COUNT_WIDTH >= 16) ? 16 : COUNT_WIDTH;

    // Sound speed scaling: distance_cm = width * SPEED_NUM / SPEED_DEN.
    localparam int SPEED_NUM  = 343;
    localparam int SPEED_DEN  = 2 * 10000;
    localparam int REM_W      = $clog2(SPEED_DEN);
    localparam int DIST_W     = 11;
    localparam int TIMEOUT_CM = 999;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd2;
    localparam int CFG_DATA_W = 16;

    localparam logic [7:0]  TRIG_LOW_RST  = 8'd2;
    localparam logic [7:0]  TRIG_HIGH_RST = 8'd10;
    localparam logic [15:0] TIMEOUT_RST   = 16'd50000;

    // Measurement phases.
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TLOW  = 3'd1;
    localparam logic [2:0] PH_THIGH = 3'd2;
    localparam logic [2:0] PH_WAIT  = 3'd3;
    localparam logic [2:0] PH_MEAS  = 3'd4;

    typedef struct packed {
        logic start_req;
        logic echo_level;
    } in_item_t;

    typedef struct packed {
        logic              trigger_level;
        logic              done_res;
        logic [DIST_W-1:0] distance_cm;
        logic              timed_out;
        logic              busy_res;
    } out_item_t;

    typedef struct packed {
        logic [7:0]  trigger_low_ticks;
        logic [7:0]  trigger_high_ticks;
        logic [15:0] timeout_ticks;
    } cfg_t;

endpackage

>>> hw/rtl/uer_fsm.sv
// Ranging sequencer: trigger timing, echo capture and distance tracking.
// Advances one tick per enabled cycle and returns that tick's result.
// Depends on uer_pkg.
module uer_fsm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  uer_pkg::in_item_t item,
    input  uer_pkg::cfg_t     cfg,
    output uer_pkg::out_item_t result
);
    import uer_pkg::*;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    logic [2:0]        phase_reg, phase_next;
    logic [7:0]        phase_ticks_reg, phase_ticks_next;
    logic [CNT_W-1:0]  wait_ticks_reg, wait_ticks_next;
    logic [CNT_W-1:0]  echo_width_reg, echo_width_next;
    logic [DIST_W-1:0] last_dist_reg, last_dist_next;
    // Running quotient and remainder of echo_width * SPEED_NUM / SPEED_DEN.
    logic [DIST_W-1:0] quot_reg, quot_next;
    logic [REM_W-1:0]  rem_reg, rem_next;

    logic [7:0]       phase_inc;
    logic [REM_W:0]   rem_sum;
    logic             trig;
    logic             done;
    logic             tmo;

    assign phase_inc = phase_ticks_reg + 8'd1;
    assign rem_sum   = {1'b0, rem_reg} + (REM_W + 1)'(SPEED_NUM);

    always_comb
    begin
        phase_next       = phase_reg;
        phase_ticks_next = phase_ticks_reg;
        wait_ticks_next  = wait_ticks_reg;
        echo_width_next  = echo_width_reg;
        last_dist_next   = last_dist_reg;
        quot_next        = quot_reg;
        rem_next         = rem_reg;
        trig             = 1'b0;
        done             = 1'b0;
        tmo              = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (item.start_req)
                begin
                    phase_ticks_next = 8'd0;
                    phase_next = (cfg.trigger_low_ticks == 8'd0) ? PH_THIGH : PH_TLOW;
                end
            end
            PH_TLOW:
            begin
                phase_ticks_next = phase_inc;
                if (phase_inc >= cfg.trigger_low_ticks)
                begin
                    phase_next       = PH_THIGH;
                    phase_ticks_next = 8'd0;
                end
            end
            PH_THIGH:
            begin
                trig             = 1'b1;
                phase_ticks_next = phase_inc;
                if (phase_inc >= cfg.trigger_high_ticks)
                begin
                    phase_next       = PH_WAIT;
                    phase_ticks_next = 8'd0;
                    wait_ticks_next  = '0;
                    echo_width_next  = '0;
                    quot_next        = '0;
                    rem_next         = '0;
                end
            end
            PH_WAIT, PH_MEAS:
            begin
                if (wait_ticks_reg < CNT_MAX)
                begin
                    wait_ticks_next = wait_ticks_reg + CNT_W'(1);
                end
                if (phase_reg == PH_MEAS && !item.echo_level)
                begin
                    last_dist_next = quot_reg;
                    done           = 1'b1;
                    phase_next     = PH_IDLE;
                end
                else
                begin
                    if (item.echo_level)
                    begin
                        if (phase_reg == PH_WAIT)
                        begin
                            phase_next      = PH_MEAS;
                            echo_width_next = CNT_W'(1);
                            quot_next       = '0;
                            rem_next        = REM_W'(SPEED_NUM);
                        end
                        else if (echo_width_reg < CNT_MAX)
                        begin
                            echo_width_next = echo_width_reg + CNT_W'(1);
                            // The step is far below the divisor, so one subtract suffices.
                            if (rem_sum >= (REM_W + 1)'(SPEED_DEN))
                            begin
                                rem_next  = REM_W'(rem_sum - (REM_W + 1)'(SPEED_DEN));
                                quot_next = quot_reg + DIST_W'(1);
                            end
                            else
                            begin
                                rem_next = REM_W'(rem_sum);
                            end
                        end
                    end
                    if (16'(wait_ticks_next) >= cfg.timeout_ticks)
                    begin
                        last_dist_next = DIST_W'(TIMEOUT_CM);
                        done           = 1'b1;
                        tmo            = 1'b1;
                        phase_next     = PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            phase_ticks_reg <= '0;
            wait_ticks_reg  <= '0;
            echo_width_reg  <= '0;
            last_dist_reg   <= '0;
            quot_reg        <= '0;
            rem_reg         <= '0;
        end
        else if (step)
        begin
            phase_reg       <= phase_next;
            phase_ticks_reg <= phase_ticks_next;
            wait_ticks_reg  <= wait_ticks_next;
            echo_width_reg  <= echo_width_next;
            last_dist_reg   <= last_dist_next;
            quot_reg        <= quot_next;
            rem_reg         <= rem_next;
        end
    end

    always_comb
    begin
        result.trigger_level = trig;
        result.done_res      = done;
        result.distance_cm   = last_dist_next;
        result.timed_out     = tmo;
        result.busy_res      = (phase_next != PH_IDLE);
    end

endmodule

>>> hw/rtl/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: channels, input and result registers,
// configuration registers. Depends on uer_pkg and uer_fsm.
//
// Usage: every input transaction on in_valid/in_stall is one microsecond tick
// carrying start_req and the sampled echo pin level. Every input transaction
// produces exactly one output transaction on out_valid/out_stall with the
// trigger level for that tick, the done flag, the distance in cm (999 with
// timed_out on a missing echo) and the busy flag.
// Each input transaction passes through the input register, then the sequencer,
// which writes the result register.
// Throughput is one tick per cycle while the receiver does not stall; the
// sequencer updates its phase and counters once per tick, and the distance is
// tracked incrementally while the echo is high, so no divider is needed.
// When the receiver stalls, the result register holds its transaction, the
// tick in the input register waits, and in_stall rises once both are full.
// Reset clears both registers, returns the sequencer to idle and loads the
// default timing registers. Configuration writes are always taken
// (cfg_ready is high) and should only be issued while the block is idle.
module ultrasonic_echo_ranger (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  uer_pkg::in_item_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output uer_pkg::out_item_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import uer_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;
    cfg_t      cfg_reg;
    out_item_t step_result;
    logic      out_free;
    logic      step;
    logic      in_take;

    assign out_free  = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                in_valid_reg <= 1'b0;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= in_data;
        end
        if (step)
        begin
            out_item_reg <= step_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.trigger_low_ticks  <= TRIG_LOW_RST;
            cfg_reg.trigger_high_ticks <= TRIG_HIGH_RST;
            cfg_reg.timeout_ticks      <= TIMEOUT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TRIG_LOW:  cfg_reg.trigger_low_ticks  <= cfg_data[7:0];
                REG_TRIG_HIGH: cfg_reg.trigger_high_ticks <= cfg_data[7:0];
                REG_TIMEOUT:   cfg_reg.timeout_ticks      <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    uer_fsm u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (step_result)
    );

endmodule

>>> bench/ultrasonic_echo_ranger_tb.sv
// Self-checking testbench for the ultrasonic echo ranger top level.
// Drives microsecond ticks and register writes, predicts every result tick
// in its own ranging model and compares them in order. Depends on uer_pkg.
module ultrasonic_echo_ranger_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import uer_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 2000000;
    localparam int unsigned HOLD_CYCLES  = 150;
    localparam int unsigned DRAIN_PAD    = 6;
    localparam int unsigned RANDOM_TICKS = 200;
    localparam int unsigned MAX_REPORTS  = 10;

    localparam logic [31:0] SOUND_MUL = 32'd343;
    localparam logic [31:0] SOUND_DIV = 32'd20000;
    localparam logic [10:0] NO_ECHO_CM = 11'd999;
    localparam logic [15:0] COUNT_MAX = 16'((32'd1 << CNT_W) - 32'd1);

    // Index past the last register; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        RG_IDLE,
        RG_TRIG_LOW,
        RG_TRIG_HIGH,
        RG_LISTEN,
        RG_ECHO
    } range_phase_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    in_item_t              in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Ranging model state and its copy of the timing registers.
    range_phase_t rg_phase;
    logic [7:0]   rg_count;
    logic [15:0]  rg_wait;
    logic [15:0]  rg_width;
    logic [10:0]  rg_dist;
    logic [7:0]   cfg_low;
    logic [7:0]   cfg_high;
    logic [15:0]  cfg_timeout;

    out_item_t tick_results[$];

    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned ticks_sent;
    int unsigned ranging_runs;
    int unsigned done_seen;
    int unsigned timeouts_seen;
    int unsigned settings_applied;
    int unsigned burst_left;
    bit          gaps_on;
    bit          valid_up;
    int unsigned hold_tag;
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned stall_pct;
    int unsigned stall_mode_cycles;

    ultrasonic_echo_ranger uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("ERROR: %s", what);
    endfunction

    // Advances the ranging model by one tick and returns the result it predicts.
    function automatic out_item_t advance_ranger(input in_item_t tick);
        out_item_t   res;
        logic [31:0] product;
        res = '0;
        case (rg_phase)
            RG_IDLE:
            begin
                if (tick.start_req)
                begin
                    rg_count = 8'd0;
                    rg_phase = (cfg_low == 8'd0) ? RG_TRIG_HIGH : RG_TRIG_LOW;
                end
            end
            RG_TRIG_LOW:
            begin
                rg_count = rg_count + 8'd1;
                if (rg_count >= cfg_low)
                begin
                    rg_phase = RG_TRIG_HIGH;
                    rg_count = 8'd0;
                end
            end
            RG_TRIG_HIGH:
            begin
                res.trigger_level = 1'b1;
                rg_count = rg_count + 8'd1;
                if (rg_count >= cfg_high)
                begin
                    rg_phase = RG_LISTEN;
                    rg_count = 8'd0;
                    rg_wait  = 16'd0;
                    rg_width = 16'd0;
                end
            end
            RG_LISTEN, RG_ECHO:
            begin
                if (rg_wait != COUNT_MAX)
                    rg_wait = rg_wait + 16'd1;
                // A falling echo completes the measurement even on the timeout tick.
                if (rg_phase == RG_ECHO && !tick.echo_level)
                begin
                    product = {16'd0, rg_width} * SOUND_MUL;
                    rg_dist = 11'(product / SOUND_DIV);
                    res.done_res = 1'b1;
                    rg_phase = RG_IDLE;
                end
                else
                begin
                    if (tick.echo_level)
                    begin
                        if (rg_phase == RG_LISTEN)
                        begin
                            rg_phase = RG_ECHO;
                            rg_width = 16'd1;
                        end
                        else if (rg_width != COUNT_MAX)
                        begin
                            rg_width = rg_width + 16'd1;
                        end
                    end
                    if (rg_wait >= cfg_timeout)
                    begin
                        rg_dist = NO_ECHO_CM;
                        res.done_res = 1'b1;
                        res.timed_out = 1'b1;
                        rg_phase = RG_IDLE;
                    end
                end
            end
            default:
            begin
                rg_phase = RG_IDLE;
            end
        endcase
        res.distance_cm = rg_dist;
        res.busy_res = (rg_phase != RG_IDLE);
        return res;
    endfunction

    // Offers one tick and waits for its transaction. Valid is only lowered
    // at the end of a burst or on a drain, never between back-to-back ticks.
    task automatic send_tick(input logic start, input logic echo);
        in_item_t item;
        item.start_req  = start;
        item.echo_level = echo;
        if (!valid_up)
            in_valid <= 1'b1;
        valid_up = 1'b1;
        in_data <= item;
        do
            @(posedge clk);
        while (in_stall);
        tick_results.push_back(advance_ranger(item));
        ticks_sent++;
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
            burst_left = $urandom_range(1, 16);
        end
        else if (burst_left != 0)
        begin
            burst_left--;
        end
    endtask

    task automatic drain_results();
        if (valid_up)
            in_valid <= 1'b0;
        valid_up = 1'b0;
        while (tick_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // Finishes any measurement in flight with a short echo, then drains.
    task automatic settle_and_drain();
        while (rg_phase != RG_IDLE)
            send_tick(1'b0, rg_phase == RG_LISTEN);
        drain_results();
    endtask

    task automatic settle_and_drain_if_busy();
        while (rg_phase != RG_IDLE)
            send_tick(1'b0, rg_phase == RG_LISTEN);
    endtask

    // Writes all three timing registers plus a junk write past the map.
    task automatic program_ranger(input logic [7:0] low_t, input logic [7:0] high_t,
                                  input logic [15:0] tmo_t);
        logic [CFG_DATA_W-1:0] word [4];
        logic [CFG_IDX_W-1:0]  idx [4];
        word[0] = {8'($urandom), low_t};
        word[1] = {8'($urandom), high_t};
        word[2] = tmo_t;
        word[3] = 16'($urandom);
        idx = '{REG_TRIG_LOW, REG_TRIG_HIGH, REG_TIMEOUT, REG_UNUSED};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= word[i];
            do
                @(posedge clk);
            while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        cfg_low     = low_t;
        cfg_high    = high_t;
        cfg_timeout = tmo_t;
        settings_applied++;
    endtask

    // One measurement: the echo rises echo_delay ticks into the listening
    // window and stays high for echo_len ticks. A noisy run also toggles
    // start and echo where the block should ignore them.
    task automatic run_ranging(input int unsigned echo_delay, input int unsigned echo_len,
                               input bit noisy);
        int unsigned k;
        logic        echo;
        settle_and_drain_if_busy();
        k = 0;
        ranging_runs++;
        send_tick(1'b1, noisy ? 1'($urandom) : 1'b0);
        while (rg_phase != RG_IDLE)
        begin
            if (rg_phase == RG_LISTEN || rg_phase == RG_ECHO)
            begin
                echo = (k >= echo_delay) && (k < echo_delay + echo_len);
                k++;
                send_tick(noisy ? 1'($urandom) : 1'b0, echo);
            end
            else
            begin
                send_tick(noisy ? 1'($urandom) : 1'b0, noisy ? 1'($urandom) : 1'b0);
            end
        end
    endtask

    task automatic test_reset_defaults();
        // Reset timing: 2 ticks low, 10 high, long timeout.
        run_ranging(3, 20, 1'b0);
        run_ranging(0, 40, 1'b1);
        settle_and_drain();
    endtask

    task automatic test_trigger_timing();
        program_ranger(8'd0, 8'd0, 16'd30);
        run_ranging(2, 5, 1'b0);
        settle_and_drain();
        program_ranger(8'd255, 8'd1, 16'd30);
        run_ranging(1, 3, 1'b1);
        settle_and_drain();
        program_ranger(8'd1, 8'd1, 16'd30);
        run_ranging(0, 2, 1'b1);
        settle_and_drain();
    endtask

    task automatic test_echo_cases();
        program_ranger(8'd1, 8'd2, 16'd20);
        run_ranging(0, 6, 1'b0);
        // The echo falls on exactly the tick the timeout expires.
        run_ranging(4, 15, 1'b0);
        run_ranging(25, 3, 1'b0);
        run_ranging(2, 1000, 1'b0);
        settle_and_drain();
        program_ranger(8'd0, 8'd1, 16'd0);
        run_ranging(0, 3, 1'b0);
        run_ranging(5, 3, 1'b0);
        settle_and_drain();
        program_ranger(8'd3, 8'd1, 16'd1);
        run_ranging(0, 1, 1'b0);
        run_ranging(1, 2, 1'b1);
        settle_and_drain();
    endtask

    task automatic test_long_echo();
        // A long unbroken echo under the widest timeout.
        program_ranger(8'd0, 8'd1, 16'hFFFF);
        gaps_on = 1'b0;
        run_ranging(0, 120, 1'b0);
        settle_and_drain();
        gaps_on = 1'b1;
    endtask

    task automatic test_backpressure();
        program_ranger(8'd1, 8'd2, 16'd30);
        gaps_on = 1'b0;
        hold_tag <= hold_tag + 1;
        repeat (4) run_ranging(3, 8, 1'b0);
        settle_and_drain();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_ranging();
        int unsigned first;
        int unsigned runs_left;
        int unsigned pick;
        int unsigned echo_delay;
        int unsigned echo_len;
        logic [7:0]  low_t;
        logic [7:0]  high_t;
        logic [15:0] tmo_t;
        first = ticks_sent;
        runs_left = 0;
        while (ticks_sent - first < RANDOM_TICKS)
        begin
            if (runs_left == 0)
            begin
                settle_and_drain();
                pick  = $urandom_range(0, 19);
                low_t = (pick == 0) ? 8'd255 : (pick == 1) ? 8'd0 : 8'($urandom_range(1, 6));
                pick  = $urandom_range(0, 19);
                high_t = (pick == 0) ? 8'd255 : (pick == 1) ? 8'd0 : 8'($urandom_range(1, 6));
                pick  = $urandom_range(0, 19);
                tmo_t = (pick == 0) ? 16'd0 :
                        (pick == 1) ? 16'($urandom_range(100, 400)) :
                        16'($urandom_range(1, 40));
                program_ranger(low_t, high_t, tmo_t);
                runs_left = $urandom_range(3, 8);
                gaps_on = ($urandom_range(0, 3) != 0);
            end
            runs_left--;
            if ($urandom_range(0, 9) < 2)
            begin
                // Noise: arbitrary ticks, which may also start or cut a measurement.
                repeat ($urandom_range(1, 10)) send_tick(1'($urandom), 1'($urandom));
            end
            else
            begin
                echo_delay = $urandom_range(0, cfg_timeout + 4);
                echo_len = ($urandom_range(0, 7) == 0) ?
                           $urandom_range(1, cfg_timeout + 10) : $urandom_range(1, 12);
                run_ranging(echo_delay, echo_len, $urandom_range(0, 2) == 0);
            end
        end
        settle_and_drain();
    endtask

    // Receiver: picks a new stall density whenever its mode counter runs out and
    // honors requests for a long hold-off.
    always @(posedge clk)
    begin
        if (stall_mode_cycles == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 15;
                2: stall_pct = 45;
                default: stall_pct = 75;
            endcase
            stall_mode_cycles = 256;
        end
        stall_mode_cycles--;
        if (hold_tag != hold_seen)
        begin
            hold_seen = hold_tag;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (out_data.done_res === 1'b1)
                done_seen++;
            if (out_data.done_res === 1'b1 && out_data.timed_out === 1'b1)
                timeouts_seen++;
            if (tick_results.size() == 0)
            begin
                note_failure("result transaction with no tick outstanding");
            end
            else
            begin
                want = tick_results.pop_front();
                if (out_data.trigger_level !== want.trigger_level ||
                    out_data.done_res !== want.done_res ||
                    out_data.distance_cm !== want.distance_cm ||
                    out_data.timed_out !== want.timed_out ||
                    out_data.busy_res !== want.busy_res)
                begin
                    note_failure({
                        $sformatf("at %0t expected trig=%0b done=%0b dist=%0d tmo=%0b busy=%0b",
                                  $realtime, want.trigger_level, want.done_res,
                                  want.distance_cm, want.timed_out, want.busy_res),
                        $sformatf(", got trig=%0b done=%0b dist=%0d tmo=%0b busy=%0b",
                                  out_data.trigger_level, out_data.done_res,
                                  out_data.distance_cm, out_data.timed_out,
                                  out_data.busy_res)});
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Run did not finish within %0d cycles", CYCLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        fail_count        = 0;
        cycle_count       = 0;
        ticks_sent        = 0;
        ranging_runs      = 0;
        done_seen         = 0;
        timeouts_seen     = 0;
        settings_applied  = 0;
        burst_left        = 0;
        gaps_on           = 1'b1;
        valid_up          = 1'b0;
        hold_tag          = 0;
        hold_seen         = 0;
        hold_left         = 0;
        stall_pct         = 0;
        stall_mode_cycles = 0;
        rg_phase    = RG_IDLE;
        rg_count    = 8'd0;
        rg_wait     = 16'd0;
        rg_width    = 16'd0;
        rg_dist     = 11'd0;
        cfg_low     = 8'd2;
        cfg_high    = 8'd10;
        cfg_timeout = 16'd50000;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reset_defaults();
        test_trigger_timing();
        test_echo_cases();
        test_long_echo();
        test_backpressure();
        test_random_ranging();

        drain_results();
        if (tick_results.size() != 0)
            note_failure($sformatf("%0d ticks never produced a result", tick_results.size()));

        $display("Sent %0d ticks in %0d ranging runs under %0d register settings;",
                 ticks_sent, ranging_runs, settings_applied);
        $display("saw %0d finished measurements, %0d of them timeouts, %0d failures.",
                 done_seen, timeouts_seen, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
